>>> rtl/nrle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrle_pkg
// Shared types and constants for the nucleotide run-length encoder.
// ----------------------------------------------------------------------------
package nrle_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int RUN_W       = 16;
  localparam int CHAR_W      = 8;
  localparam int OUT_DATA_W  = 24;  // symbol_code + run_length, padded to bytes
  localparam int OUT_DEPTH   = 3;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h43;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h47;
  localparam logic [CHAR_W-1:0] CHAR_T = 8'h54;

  localparam logic [1:0] SYM_A = 2'b00;
  localparam logic [1:0] SYM_C = 2'b01;
  localparam logic [1:0] SYM_G = 2'b10;
  localparam logic [1:0] SYM_T = 2'b11;

  localparam logic [1:0] ERR_NONE = 2'b00;
  localparam logic [1:0] ERR_CHAR = 2'b01;
  localparam logic [1:0] ERR_LONG = 2'b10;

  typedef struct packed {
    logic              seq_end;
    logic [CHAR_W-1:0] base_char;
  } item_t;

  typedef struct packed {
    logic [1:0]       error_code;
    logic             final_run;
    logic [RUN_W-1:0] run_length;
    logic [1:0]       symbol_code;
  } res_t;

  // results produced by one item: count, then up to two entries in order
  typedef struct packed {
    logic [1:0] num;
    res_t       res1;
    res_t       res0;
  } enc_out_t;

endpackage

>>> rtl/nrle_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrle_in_stage
// Input register: holds one incoming character until the encoder takes it.
// ----------------------------------------------------------------------------
module nrle_in_stage
  import nrle_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [CHAR_W-1:0] in_tdata,
  input  logic              in_tlast,
  input  logic              take,
  output logic              item_valid,
  output item_t             item
);

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign in_tready  = !valid_r || take;
  assign load       = in_tvalid && in_tready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.base_char <= in_tdata;
      item_r.seq_end   <= in_tlast;
    end
  end

endmodule

>>> rtl/nrle_encode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrle_encode
// Run state and the per-character update; yields zero, one or two results.
// ----------------------------------------------------------------------------
module nrle_encode
  import nrle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  item_t    item,
  output enc_out_t enc
);

  logic [1:0]             sym_r, sym_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic                   open_r, open_nxt;
  logic                   disc_r, disc_nxt;

  logic       char_ok;
  logic [1:0] code;

  always_comb begin
    char_ok = 1'b1;
    case (item.base_char)
      CHAR_A:  code = SYM_A;
      CHAR_C:  code = SYM_C;
      CHAR_G:  code = SYM_G;
      CHAR_T:  code = SYM_T;
      default: begin
        code    = SYM_A;
        char_ok = 1'b0;
      end
    endcase
  end

  function automatic res_t mk_res(logic [1:0] s, logic [COUNT_WIDTH-1:0] c,
                                  logic fin, logic [1:0] err);
    res_t r;
    r.symbol_code = s;
    r.run_length  = RUN_W'(c);
    r.final_run   = fin;
    r.error_code  = err;
    return r;
  endfunction

  always_comb begin
    logic err_hit;
    logic [1:0] err;
    sym_nxt  = sym_r;
    cnt_nxt  = cnt_r;
    open_nxt = open_r;
    disc_nxt = disc_r;
    enc.num  = 2'd0;
    enc.res0 = mk_res(SYM_A, '0, 1'b1, ERR_NONE);
    enc.res1 = enc.res0;
    err_hit  = 1'b0;
    err      = ERR_NONE;

    if (disc_r) begin
      disc_nxt = !item.seq_end;
    end else begin
      if (!char_ok) begin
        err_hit = 1'b1;
        err     = ERR_CHAR;
      end else if (!open_r) begin
        sym_nxt  = code;
        cnt_nxt  = COUNT_WIDTH'(1);
        open_nxt = 1'b1;
      end else if (code == sym_r) begin
        if (cnt_r == '1) begin
          err_hit = 1'b1;
          err     = ERR_LONG;
        end else begin
          cnt_nxt = cnt_r + COUNT_WIDTH'(1);
        end
      end else begin
        // symbol change: finished run goes out first
        enc.res0 = mk_res(sym_r, cnt_r, 1'b0, ERR_NONE);
        enc.num  = 2'd1;
        sym_nxt  = code;
        cnt_nxt  = COUNT_WIDTH'(1);
      end

      if (err_hit) begin
        enc.res0 = mk_res(SYM_A, '0, 1'b1, err);
        enc.num  = 2'd1;
        sym_nxt  = SYM_A;
        cnt_nxt  = '0;
        open_nxt = 1'b0;
        disc_nxt = !item.seq_end;
      end else if (item.seq_end) begin
        if (enc.num == 2'd0) begin
          enc.res0 = mk_res(sym_nxt, cnt_nxt, 1'b1, ERR_NONE);
        end else begin
          enc.res1 = mk_res(sym_nxt, cnt_nxt, 1'b1, ERR_NONE);
        end
        enc.num  = enc.num + 2'd1;
        sym_nxt  = SYM_A;
        cnt_nxt  = '0;
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_r  <= SYM_A;
      cnt_r  <= '0;
      open_r <= 1'b0;
      disc_r <= 1'b0;
    end else if (fire) begin
      sym_r  <= sym_nxt;
      cnt_r  <= cnt_nxt;
      open_r <= open_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

>>> rtl/nrle_out_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrle_out_queue
// Three-entry result queue; takes up to two results per cycle while room is set, emits one while out_tready is high.
// ----------------------------------------------------------------------------
module nrle_out_queue
  import nrle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  enc_out_t enc,
  output logic     room,
  output logic     out_tvalid,
  input  logic     out_tready,
  output res_t     head
);

  res_t       q_r   [OUT_DEPTH];
  res_t       q_nxt [OUT_DEPTH];
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] base;
  logic [1:0] npush;

  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid && out_tready;
  assign head       = q_r[0];
  // room for two regardless of the drain side, keeps ready off the output path
  assign room       = (cnt_r <= 2'd1);
  assign npush      = push ? enc.num : 2'd0;
  assign base       = cnt_r - {1'b0, pop};
  assign cnt_nxt    = base + npush;

  always_comb begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      if (pop && i < OUT_DEPTH - 1) begin
        q_nxt[i] = q_r[i+1];
      end else begin
        q_nxt[i] = q_r[i];
      end
      if (npush != 2'd0 && 2'(i) == base) begin
        q_nxt[i] = enc.res0;
      end
      if (npush == 2'd2 && 2'(i) == base + 2'd1) begin
        q_nxt[i] = enc.res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < OUT_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

endmodule

>>> rtl/nucleotide_run_length_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nucleotide_run_length_encoder_core
// Run-length encoder for A/C/G/T character streams with error reporting.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tlast     | tuser
//  in_     | in  | [7:0] base_char                | seq_end   | -
//  out_    | out | [1:0] symbol_code,[17:2] run_length | final_run | [1:0] error_code
//
//  One character per cycle while the result queue has room; a character is held in the
//  input register, and any result it yields is written into the result queue. A symbol change
//  on an end character gives two results; the three-entry result queue then pauses input until its fill drops to one.
//  Input ready depends only on registered state (input register and queue fill), not on out_tready.
//  Synchronous active-low reset clears run state and empties both stages.
// ----------------------------------------------------------------------------
module nucleotide_run_length_encoder_core
  import nrle_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [CHAR_W-1:0]     in_tdata,   // [7:0] base_char
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [1:0] symbol_code, [17:2] run_length
  output logic                  out_tlast,
  output logic [1:0]            out_tuser   // [1:0] error_code
);

  logic     item_valid;
  item_t    item;
  logic     room;
  logic     fire;
  enc_out_t enc;
  res_t     head;

  assign fire = item_valid && room;

  nrle_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  nrle_encode u_enc (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item),
    .enc   (enc)
  );

  nrle_out_queue u_q (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .enc        (enc),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .head       (head)
  );

  assign out_tdata = {(OUT_DATA_W - RUN_W - 2)'(0), head.run_length, head.symbol_code};
  assign out_tlast = head.final_run;
  assign out_tuser = head.error_code;

endmodule

>>> rtl/nrle_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrle_checker
// Port-level checks for the run-length encoder, bound to the top level.
// ----------------------------------------------------------------------------
module nrle_checker
  import nrle_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast,
  input logic [1:0]            out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ERR_NONE |->
      out_tdata == '0 && out_tlast && (out_tuser == ERR_CHAR || out_tuser == ERR_LONG))
    else $error("malformed error result");

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ERR_NONE |-> out_tdata[RUN_W+1:2] != '0)
    else $error("good run with zero length");

  // with nothing queued on the result side the block always takes input
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !out_tvalid |-> in_tready)
    else $error("input stalled with empty result queue");

endmodule

bind nucleotide_run_length_encoder_core nrle_checker u_nrle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);
